// ===== sv/rsa_pkg.sv =====
`default_nettype none

package rsa_pkg;

  // widths of the stream fields, fixed by the interface
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned PART_CNT_W  = 40;
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned OUT_COUNT_W = 40;
  localparam int unsigned OP_W        = 2;

  localparam int unsigned IN_DATA_W  = 264;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 240;

  // operation codes carried in the low bits of in_tuser
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_MERGE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic                         sample_valid;
    logic signed [SAMPLE_W-1:0]   sample;
    logic [PART_CNT_W-1:0]        part_count;
    logic signed [SUM_W-1:0]      part_sum;
    logic signed [SAMPLE_W-1:0]   part_min;
    logic signed [SAMPLE_W-1:0]   part_max;
    logic [SUM_W-1:0]             part_sumsq;
  } item_t;

  // item after the square stage: sample is sign-extended, sq is its scaled square
  typedef struct packed {
    item_t            item;
    logic [SUM_W-1:0] sq;
  } sq_item_t;

endpackage

`default_nettype wire

// ===== sv/rsa_square.sv =====
`default_nettype none

module rsa_square #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rsa_pkg::item_t    in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rsa_pkg::sq_item_t      out_item
);

  localparam int unsigned PROD_W = 2 * SAMPLE_BITS;

  logic              s1_v_r;
  logic              s1_v_nxt;
  rsa_pkg::item_t    s1_r;
  logic              s2_v_r;
  logic              s2_v_nxt;
  rsa_pkg::sq_item_t s2_r;
  rsa_pkg::sq_item_t s2_nxt;

  logic                   s1_adv;
  logic                   s2_adv;
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic [PROD_W-1:0]      prod;

  assign s2_adv   = !s2_v_r || out_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  assign s1_v_nxt = s1_adv ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_adv ? s1_v_r : s2_v_r;

  // only the low SAMPLE_BITS of the sample count, sign-extended
  assign raw  = s1_r.sample[SAMPLE_BITS-1:0];
  assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  assign prod = PROD_W'(mag) * PROD_W'(mag);

  always_comb begin
    s2_nxt             = '0;
    s2_nxt.item        = s1_r;
    s2_nxt.item.sample = rsa_pkg::SAMPLE_W'($signed(raw));
    s2_nxt.sq          = rsa_pkg::SUM_W'(prod >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_r <= in_item;
    end
    if (s2_adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_item  = s2_r;

endmodule

`default_nettype wire

// ===== sv/rsa_accum.sv =====
`default_nettype none

module rsa_accum #(
  parameter int unsigned COUNT_BITS = 40
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire rsa_pkg::sq_item_t                  in_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [rsa_pkg::OUT_COUNT_W-1:0]         total_count,
  output logic signed [rsa_pkg::SUM_W-1:0]        total_sum,
  output logic [rsa_pkg::SUM_W-1:0]               total_sumsq,
  output logic signed [rsa_pkg::SAMPLE_W-1:0]     lowest,
  output logic signed [rsa_pkg::SAMPLE_W-1:0]     highest,
  output logic                                    overflowed
);

  localparam int unsigned SW     = rsa_pkg::SUM_W;
  localparam int unsigned VW     = rsa_pkg::SAMPLE_W;
  localparam int unsigned WIDE_C =
    (COUNT_BITS > rsa_pkg::OUT_COUNT_W) ? COUNT_BITS : rsa_pkg::OUT_COUNT_W;
  localparam int unsigned CSUM_W = WIDE_C + 1;

  logic                   out_v_r;
  logic                   out_v_nxt;
  logic [COUNT_BITS-1:0]  cnt_r;
  logic [COUNT_BITS-1:0]  cnt_nxt;
  logic signed [SW-1:0]   sum_r;
  logic signed [SW-1:0]   sum_nxt;
  logic [SW-1:0]          sumsq_r;
  logic [SW-1:0]          sumsq_nxt;
  logic signed [VW-1:0]   min_r;
  logic signed [VW-1:0]   min_nxt;
  logic signed [VW-1:0]   max_r;
  logic signed [VW-1:0]   max_nxt;
  logic                   sat_r;
  logic                   sat_nxt;

  logic                   land;
  rsa_pkg::item_t         it;
  logic                   is_add;
  logic                   empty;
  logic [CSUM_W-1:0]      cnt_lim;
  logic [CSUM_W-1:0]      cnt_sum;
  logic                   cnt_ovf;
  logic [COUNT_BITS-1:0]  cnt_new;
  logic signed [SW-1:0]   sum_opnd;
  logic signed [SW-1:0]   sum_raw;
  logic                   sum_ovf;
  logic signed [SW-1:0]   sum_new;
  logic [SW-1:0]          sumsq_opnd;
  logic [SW:0]            sumsq_raw;
  logic [SW-1:0]          sumsq_new;

  assign in_ready = !out_v_r || out_ready;
  assign land     = in_valid && in_ready;
  assign it       = in_item.item;
  assign is_add   = (it.op == rsa_pkg::OP_ADD);
  assign empty    = (cnt_r == '0);

  // count: one for a sample, the partial's count for a merge
  assign cnt_lim = CSUM_W'({COUNT_BITS{1'b1}});
  assign cnt_sum = CSUM_W'(cnt_r)
                 + (is_add ? CSUM_W'(1'b1) : CSUM_W'(it.part_count));
  assign cnt_ovf = (cnt_sum > cnt_lim);
  assign cnt_new = cnt_ovf ? {COUNT_BITS{1'b1}} : COUNT_BITS'(cnt_sum);

  assign sum_opnd = is_add ? SW'(it.sample) : it.part_sum;
  assign sum_raw  = sum_r + sum_opnd;
  assign sum_ovf  = (sum_r[SW-1] == sum_opnd[SW-1]) && (sum_raw[SW-1] != sum_r[SW-1]);
  assign sum_new  = !sum_ovf ? sum_raw
                  : (sum_r[SW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

  assign sumsq_opnd = is_add ? in_item.sq : it.part_sumsq;
  assign sumsq_raw  = {1'b0, sumsq_r} + {1'b0, sumsq_opnd};
  assign sumsq_new  = sumsq_raw[SW] ? {SW{1'b1}} : sumsq_raw[SW-1:0];

  always_comb begin
    out_v_nxt = in_ready ? in_valid : out_v_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sat_nxt   = sat_r;
    if (land) begin
      unique case (it.op)
        rsa_pkg::OP_ADD: begin
          if (it.sample_valid) begin
            cnt_nxt   = cnt_new;
            sum_nxt   = sum_new;
            sumsq_nxt = sumsq_new;
            sat_nxt   = sat_r | cnt_ovf | sum_ovf | sumsq_raw[SW];
            if (empty) begin
              min_nxt = it.sample;
              max_nxt = it.sample;
            end else begin
              if (it.sample < min_r) min_nxt = it.sample;
              if (it.sample > max_r) max_nxt = it.sample;
            end
          end
        end
        rsa_pkg::OP_MERGE: begin
          cnt_nxt   = cnt_new;
          sum_nxt   = sum_new;
          sumsq_nxt = sumsq_new;
          sat_nxt   = sat_r | cnt_ovf | sum_ovf | sumsq_raw[SW];
          // an empty partial brings no extremes
          if (it.part_count != '0) begin
            if (empty) begin
              min_nxt = it.part_min;
              max_nxt = it.part_max;
            end else begin
              if (it.part_min < min_r) min_nxt = it.part_min;
              if (it.part_max > max_r) max_nxt = it.part_max;
            end
          end
        end
        rsa_pkg::OP_CLEAR: begin
          cnt_nxt   = '0;
          sum_nxt   = '0;
          sumsq_nxt = '0;
          min_nxt   = '0;
          max_nxt   = '0;
          sat_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      cnt_r   <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      sat_r   <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid   = out_v_r;
  assign total_count = (CSUM_W'(cnt_r) > CSUM_W'({rsa_pkg::OUT_COUNT_W{1'b1}}))
                     ? {rsa_pkg::OUT_COUNT_W{1'b1}} : rsa_pkg::OUT_COUNT_W'(cnt_r);
  assign total_sum   = sum_r;
  assign total_sumsq = sumsq_r;
  assign lowest      = empty ? '0 : min_r;
  assign highest     = empty ? '0 : max_r;
  assign overflowed  = sat_r;

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    land && (it.op == rsa_pkg::OP_CLEAR) |=> (cnt_r == '0) && !sat_r && (sum_r == '0))
    else $error("clear beat did not zero the aggregate");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r && !(land && (it.op == rsa_pkg::OP_CLEAR)) |=> sat_r)
    else $error("saturation flag dropped without a clear");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !land |=> $stable(cnt_r) && $stable(sum_r) && $stable(sumsq_r))
    else $error("aggregate changed with no beat landing");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    land && is_add && it.sample_valid && !cnt_ovf |=> (cnt_r == $past(cnt_new)) && !empty)
    else $error("sample beat did not advance the count");

endmodule

`default_nettype wire

// ===== sv/running_stats_accumulator_unit.sv =====
`default_nettype none

// Running statistics over a stream of signed Q16.16 samples: count, sum, sum of
// squares, minimum and maximum. Each input beat (op in in_tuser: add sample,
// merge partial aggregate, clear) returns one output beat with the aggregate as
// it stands after that beat. Count and sums saturate and set the sticky
// overflowed flag; clear resets it. The block takes one beat every cycle unless
// the output stalls with all stages full; a beat passes an input register, the
// square stage (one SAMPLE_BITS x SAMPLE_BITS multiply) and the accumulate stage,
// whose registered aggregate is held as the output beat until out_tready is high,
// and a stalled output holds the pipeline back only once all three stages are full.
module running_stats_accumulator_unit #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COUNT_BITS  = 40
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // sample, part_count, part_sum, part_min, part_max, part_sumsq
  input  wire logic [rsa_pkg::IN_DATA_W-1:0]     in_tdata,
  // op, sample_valid
  input  wire logic [rsa_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // total_count, total_sum, total_sumsq, lowest, highest, overflowed, zero pad
  output logic [rsa_pkg::OUT_DATA_W-1:0]         out_tdata
);

  rsa_pkg::item_t    in_item;
  rsa_pkg::sq_item_t sq_item;
  logic              sq_valid;
  logic              sq_ready;

  logic [rsa_pkg::OUT_COUNT_W-1:0]     total_count;
  logic signed [rsa_pkg::SUM_W-1:0]    total_sum;
  logic [rsa_pkg::SUM_W-1:0]           total_sumsq;
  logic signed [rsa_pkg::SAMPLE_W-1:0] lowest;
  logic signed [rsa_pkg::SAMPLE_W-1:0] highest;
  logic                                overflowed;

  always_comb begin
    in_item.op           = in_tuser[1:0];
    in_item.sample_valid = in_tuser[2];
    in_item.sample       = in_tdata[31:0];
    in_item.part_count   = in_tdata[71:32];
    in_item.part_sum     = in_tdata[135:72];
    in_item.part_min     = in_tdata[167:136];
    in_item.part_max     = in_tdata[199:168];
    in_item.part_sumsq   = in_tdata[263:200];
  end

  rsa_square #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_valid(sq_valid),
    .out_ready(sq_ready),
    .out_item (sq_item)
  );

  rsa_accum #(
    .COUNT_BITS(COUNT_BITS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sq_valid),
    .in_ready   (sq_ready),
    .in_item    (sq_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .total_count(total_count),
    .total_sum  (total_sum),
    .total_sumsq(total_sumsq),
    .lowest     (lowest),
    .highest    (highest),
    .overflowed (overflowed)
  );

  assign out_tdata = {7'b0, overflowed, highest, lowest, total_sumsq, total_sum, total_count};

endmodule

`default_nettype wire
